// ----- sv/cacs_pkg.sv -----
// Shared types, constants and helpers for the cross sharpening core.
`default_nettype none

package cacs_pkg;

  // Depths of the job queue and the result queue.
  localparam int JQ_DEPTH = 4;
  localparam int JQ_CNTW  = $clog2(JQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CNTW  = $clog2(OQ_DEPTH + 1);

  localparam int CFG_DW   = 12;
  localparam int CFG_AW   = 2;
  localparam int POS_W    = 11;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1920;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1080;
  localparam logic [8:0]  SHARPNESS_RST    = 9'd128;

  typedef enum logic [CFG_AW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SHARPNESS    = 2'd2
  } cfg_reg_e;

  // Red sits in the low byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    pix_t center;
    pix_t left;
    pix_t right;
    pix_t top;
    pix_t bottom;
    pix_t border;
    logic is_int;
    logic is_bor;
  } job_t;

  typedef struct packed {
    pix_t             pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } res_t;

  function automatic logic [15:0] luma(pix_t p);
    luma = 16'(p.red) * 16'd77 + 16'(p.green) * 16'd150 + 16'(p.blue) * 16'd29;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cacs_fifo.sv -----
// Small flop queue with two write ports and one read port.
`default_nettype none

module cacs_fifo #(
  parameter int DW    = 32,
  parameter int DEPTH = 4,
  localparam int AW   = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr0_i,
  input  wire logic [DW-1:0]   wd0_i,
  input  wire logic            wr1_i,
  input  wire logic [DW-1:0]   wd1_i,
  input  wire logic            rd_i,
  output logic      [DW-1:0]   rdata_o,
  output logic                 empty_o,
  output logic      [CNTW-1:0] cnt_o
);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            rd_ok;

  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign rd_ok   = rd_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q + AW'(wr0_i) + AW'(wr1_i);
    rptr_d = rptr_q + AW'(rd_ok);
    cnt_d  = cnt_q + CNTW'(wr0_i) + CNTW'(wr1_i) - CNTW'(rd_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr0_i) begin
      mem_q[wptr_q] <= wd0_i;
    end
    if (wr1_i) begin
      mem_q[wptr_q + AW'(1)] <= wd1_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr0_i && !wr1_i) |-> (cnt_q < CNTW'(DEPTH)))
    else $error("queue written while full");
  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr1_i |-> (wr0_i && (cnt_q < CNTW'(DEPTH - 1))))
    else $error("queue pair write without two free slots");
`endif

endmodule

`default_nettype wire

// ----- sv/cacs_front.sv -----
// Front end: position tracking, line stores, cross window and classification.
`default_nettype none

module cacs_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire cacs_pkg::pix_t               pix_i,
  input  wire logic                         frame_start_i,
  input  wire logic [11:0]                  frame_width_i,
  input  wire logic [11:0]                  frame_height_i,
  input  wire logic [cacs_pkg::JQ_CNTW-1:0] jq_cnt_i,
  output logic                              job_v_o,
  output cacs_pkg::job_t                    job_o,
  output logic [CW-1:0]                     job_col_o,
  output logic [RW-1:0]                     job_row_o
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = (WW > 12) ? ((HW > WW) ? HW : WW) : ((HW > 12) ? HW : 12);
  localparam int JQ_CNTW_X = cacs_pkg::JQ_CNTW + 1;

  logic [CMPW-1:0] fw_x, fh_x;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  logic [CW-1:0]   col_q, col_d, col_base, col_s;
  logic [RW-1:0]   row_q, row_d, row_base, row_s;
  logic [RW:0]     row_wrap;
  logic [WW-1:0]   col_inc;
  logic [HW-1:0]   row_inc;
  logic            is_int, is_bor, acc;

  // Second stage: memory read data is back, write and shift the window.
  logic            f2_v_q;
  logic [CW-1:0]   f2_col_q;
  logic [RW-1:0]   f2_row_q;
  cacs_pkg::pix_t  f2_pix_q;
  logic            f2_int_q, f2_bor_q;
  cacs_pkg::pix_t  rd1_q, rd2_q, up1, up2;
  logic            byp_v_q;
  cacs_pkg::pix_t  byp1_q, byp2_q;

  cacs_pkg::pix_t  line1_q [MAX_WIDTH];
  cacs_pkg::pix_t  line2_q [MAX_WIDTH];

  cacs_pkg::pix_t  w2_q, w4_q, w5_q, w8_q;

  // Effective frame size: zero acts as one, oversize saturates.
  always_comb begin
    fw_x = CMPW'(frame_width_i);
    fh_x = CMPW'(frame_height_i);
    if (fw_x == '0) begin
      w_eff = WW'(1);
    end else if (fw_x > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_x);
    end
    if (fh_x == '0) begin
      h_eff = HW'(1);
    end else if (fh_x > CMPW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_x);
    end
  end

  // Position of the arriving pixel and of the next one.
  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    col_s    = col_base;
    row_wrap = (RW+1)'(row_base);
    if (WW'(col_base) >= w_eff) begin
      col_s    = '0;
      row_wrap = (RW+1)'(row_base) + (RW+1)'(1);
    end
    if (row_wrap >= (RW+1)'(h_eff)) begin
      row_s = '0;
    end else begin
      row_s = RW'(row_wrap);
    end

    is_int = (col_s >= CW'(2)) && (row_s >= RW'(2));
    is_bor = (col_s == '0) || (row_s == '0) ||
             (WW'(col_s) == w_eff - WW'(1)) || (HW'(row_s) == h_eff - HW'(1));

    col_inc = WW'(col_s) + WW'(1);
    row_inc = HW'(row_s);
    col_d   = CW'(col_inc);
    row_d   = row_s;
    if (col_inc >= w_eff) begin
      col_d   = '0;
      row_inc = HW'(row_s) + HW'(1);
      row_d   = (row_inc >= h_eff) ? '0 : RW'(row_inc);
    end
  end

  // Hold off while the job queue could not take this word and the one in flight.
  assign full_o = ((JQ_CNTW_X)'(jq_cnt_i) + (JQ_CNTW_X)'(f2_v_q)) >=
                  (JQ_CNTW_X)'(cacs_pkg::JQ_DEPTH);

  assign acc = push_i && !full_o;

  // A read issued on the edge of the previous write misses it: forward.
  assign up1 = byp_v_q ? byp1_q : rd1_q;
  assign up2 = byp_v_q ? byp2_q : rd2_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd1_q <= line1_q[col_s];
      rd2_q <= line2_q[col_s];
    end
    if (f2_v_q) begin
      line1_q[f2_col_q] <= f2_pix_q;
      line2_q[f2_col_q] <= up1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f2_col_q <= col_s;
      f2_row_q <= row_s;
      f2_pix_q <= pix_i;
      f2_int_q <= is_int;
      f2_bor_q <= is_bor;
      byp1_q   <= f2_pix_q;
      byp2_q   <= up1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      f2_v_q  <= 1'b0;
      byp_v_q <= 1'b0;
      w2_q    <= '0;
      w4_q    <= '0;
      w5_q    <= '0;
      w8_q    <= '0;
    end else begin
      f2_v_q  <= acc;
      byp_v_q <= acc && f2_v_q && (col_s == f2_col_q);
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (f2_v_q) begin
        w2_q <= up2;
        w4_q <= w5_q;
        w5_q <= up1;
        w8_q <= f2_pix_q;
      end
    end
  end

  always_comb begin
    job_o.center = w5_q;
    job_o.left   = w4_q;
    job_o.right  = up1;
    job_o.top    = w2_q;
    job_o.bottom = w8_q;
    job_o.border = f2_pix_q;
    job_o.is_int = f2_int_q;
    job_o.is_bor = f2_bor_q;
  end

  assign job_v_o   = f2_v_q && (f2_int_q || f2_bor_q);
  assign job_col_o = f2_col_q;
  assign job_row_o = f2_row_q;

`ifndef ASSERT_OFF
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> f2_v_q)
    else $error("accepted word did not reach the store stage");
  a_bypass_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_v_q |-> (f2_v_q && $past(f2_v_q)))
    else $error("forwarding without a write on the read edge");
`endif

endmodule

`default_nettype wire

// ----- sv/cacs_back.sv -----
// Back end: five-stage luma, contrast, gain and sharpen pipeline.
`default_nettype none

module cacs_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [8:0]                   sharpness_i,
  input  wire logic                         jq_empty_i,
  output logic                              jq_pop_o,
  input  wire cacs_pkg::job_t               job_i,
  input  wire logic [CW-1:0]                job_col_i,
  input  wire logic [RW-1:0]                job_row_i,
  input  wire logic [cacs_pkg::OQ_CNTW-1:0] oq_cnt_i,
  output logic                              oq_wr0_o,
  output cacs_pkg::res_t                    oq_wd0_o,
  output logic                              oq_wr1_o,
  output cacs_pkg::res_t                    oq_wd1_o
);

  localparam int XCW = (CW > cacs_pkg::POS_W) ? CW : cacs_pkg::POS_W;
  localparam int XRW = (RW > cacs_pkg::POS_W) ? RW : cacs_pkg::POS_W;

  typedef struct packed {
    logic           is_int;
    logic           is_bor;
    cacs_pkg::pix_t center;
    cacs_pkg::pix_t border;
    logic [CW-1:0]  col;
    logic [RW-1:0]  row;
  } tail_t;

  logic adv;

  logic               b1_v_q, b2_v_q, b3_v_q, b4_v_q, b5_v_q;
  tail_t              b1_tail_q, b2_tail_q, b3_tail_q, b4_tail_q, b5_tail_q;
  logic        [15:0] b1_luma_q [5];
  logic signed [10:0] b1_diff_q [3];
  logic signed [10:0] b2_diff_q [3];
  logic signed [10:0] b3_diff_q [3];
  logic        [15:0] b2_c_q;
  logic        [16:0] b3_gain_q;
  logic signed [28:0] b4_prod_q [3];
  logic        [7:0]  b5_rgb_q [3];

  tail_t              tail_in;
  logic        [15:0] luma_d [5];
  logic signed [10:0] diff_d [3];
  logic        [15:0] mn, mx;
  logic        [8:0]  s_eff, lim;
  logic        [17:0] gain_full;
  logic signed [17:0] gain_s;
  logic signed [28:0] prod_d [3];
  logic signed [30:0] num;
  logic        [7:0]  rgb_d [3];
  logic        [9:0]  nsum;
  logic        [7:0]  cen;

  cacs_pkg::res_t     int_res, bor_res;
  logic [XCW-1:0]     col_x, icol_x;
  logic [XRW-1:0]     row_x, irow_x;

  // Advance the whole pipe only when the result queue can take a pair.
  assign adv      = oq_cnt_i <= cacs_pkg::OQ_CNTW'(cacs_pkg::OQ_DEPTH - 2);
  assign jq_pop_o = adv && !jq_empty_i;

  always_comb begin
    tail_in.is_int = job_i.is_int;
    tail_in.is_bor = job_i.is_bor;
    tail_in.center = job_i.center;
    tail_in.border = job_i.border;
    tail_in.col    = job_col_i;
    tail_in.row    = job_row_i;

    luma_d[0] = cacs_pkg::luma(job_i.center);
    luma_d[1] = cacs_pkg::luma(job_i.left);
    luma_d[2] = cacs_pkg::luma(job_i.right);
    luma_d[3] = cacs_pkg::luma(job_i.top);
    luma_d[4] = cacs_pkg::luma(job_i.bottom);

    // 4*centre minus the four neighbours, per colour.
    for (int k = 0; k < 3; k++) begin
      cen  = job_i.center[8*k +: 8];
      nsum = 10'(job_i.left[8*k +: 8]) + 10'(job_i.right[8*k +: 8]) +
             10'(job_i.top[8*k +: 8]) + 10'(job_i.bottom[8*k +: 8]);
      diff_d[k] = $signed({1'b0, cen, 2'b00}) - $signed({1'b0, nsum});
    end
  end

  always_comb begin
    mn = b1_luma_q[0];
    mx = b1_luma_q[0];
    for (int i = 1; i < 5; i++) begin
      if (b1_luma_q[i] < mn) begin
        mn = b1_luma_q[i];
      end
      if (b1_luma_q[i] > mx) begin
        mx = b1_luma_q[i];
      end
    end
  end

  always_comb begin
    s_eff     = (sharpness_i > 9'd256) ? 9'd256 : sharpness_i;
    lim       = (b2_c_q >= 16'd64) ? 9'd256 : 9'({b2_c_q[6:0], 2'b00});
    gain_full = 18'(s_eff) * 18'(lim);
    gain_s    = $signed({1'b0, b3_gain_q});
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = 29'(gain_s) * 29'(b3_diff_q[k]);
    end
  end

  // Add the scaled centre, drop 19 fraction bits and clamp.
  always_comb begin
    num = '0;
    for (int k = 0; k < 3; k++) begin
      num = $signed({4'b0000, b4_tail_q.center[8*k +: 8], 19'b0}) + 31'(b4_prod_q[k]);
      if (num[30]) begin
        rgb_d[k] = 8'd0;
      end else if (|num[29:27]) begin
        rgb_d[k] = 8'd255;
      end else begin
        rgb_d[k] = num[26:19];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      b4_v_q <= 1'b0;
      b5_v_q <= 1'b0;
    end else if (adv) begin
      b1_v_q <= jq_pop_o;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
      b4_v_q <= b3_v_q;
      b5_v_q <= b4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_tail_q <= tail_in;
      b1_luma_q <= luma_d;
      b1_diff_q <= diff_d;
      b2_tail_q <= b1_tail_q;
      b2_diff_q <= b1_diff_q;
      b2_c_q    <= mx - mn;
      b3_tail_q <= b2_tail_q;
      b3_diff_q <= b2_diff_q;
      b3_gain_q <= gain_full[16:0];
      b4_tail_q <= b3_tail_q;
      b4_prod_q <= prod_d;
      b5_tail_q <= b4_tail_q;
      b5_rgb_q  <= rgb_d;
    end
  end

  always_comb begin
    col_x  = XCW'(b5_tail_q.col);
    row_x  = XRW'(b5_tail_q.row);
    icol_x = XCW'(b5_tail_q.col - CW'(1));
    irow_x = XRW'(b5_tail_q.row - RW'(1));

    int_res.pix.alpha = b5_tail_q.center.alpha;
    int_res.pix.blue  = b5_rgb_q[2];
    int_res.pix.green = b5_rgb_q[1];
    int_res.pix.red   = b5_rgb_q[0];
    int_res.col       = icol_x[cacs_pkg::POS_W-1:0];
    int_res.row       = irow_x[cacs_pkg::POS_W-1:0];
    int_res.last      = !b5_tail_q.is_bor;

    bor_res.pix  = b5_tail_q.border;
    bor_res.col  = col_x[cacs_pkg::POS_W-1:0];
    bor_res.row  = row_x[cacs_pkg::POS_W-1:0];
    bor_res.last = 1'b1;
  end

  // Interior word first, the border word behind it.
  assign oq_wr0_o = adv && b5_v_q && (b5_tail_q.is_int || b5_tail_q.is_bor);
  assign oq_wd0_o = b5_tail_q.is_int ? int_res : bor_res;
  assign oq_wr1_o = adv && b5_v_q && b5_tail_q.is_int && b5_tail_q.is_bor;
  assign oq_wd1_o = bor_res;

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && b5_v_q) |=> (b5_v_q && $stable(b5_rgb_q[0]) && $stable(b5_tail_q)))
    else $error("last stage changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- sv/contrast_adaptive_cross_sharpen_core.sv -----
// Top level: configuration registers, front end, job queue, back end, result queue.
//
//  channel   handshake          payload
//  input     push / full        pix_red_i pix_green_i pix_blue_i pix_alpha_i frame_start_i
//  result    empty / pop        out_red_o out_green_o out_blue_o out_alpha_o
//                               out_col_o out_row_o run_last_o
//  config    cfg_we_i           cfg_idx_i cfg_data_i (no wait, no read-back)
//
//  One pixel per clock while results are popped; the front's line store port pair and the
//  five-stage sharpen pipe each move one word per cycle while not stalled.
//  Results pass the store stage, job queue, sharpen pipe and result queue.
//  The sharpen pipe stalls as a whole while fewer than two result slots are free;
//  full rises when the four-entry job queue plus the word in flight would overflow.
//  Reset clears counters, window and queues; the line stores are not cleared.
`default_nettype none

module contrast_adaptive_cross_sharpen_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    pix_red_i,
  input  wire logic [7:0]                    pix_green_i,
  input  wire logic [7:0]                    pix_blue_i,
  input  wire logic [7:0]                    pix_alpha_i,
  input  wire logic                          frame_start_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         out_red_o,
  output logic [7:0]                         out_green_o,
  output logic [7:0]                         out_blue_o,
  output logic [7:0]                         out_alpha_o,
  output logic [10:0]                        out_col_o,
  output logic [10:0]                        out_row_o,
  output logic                               run_last_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cacs_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  wire logic [cacs_pkg::CFG_DW-1:0]   cfg_data_i
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int JOBW = $bits(cacs_pkg::job_t);
  localparam int JQW  = JOBW + CW + RW;
  localparam int OQW  = $bits(cacs_pkg::res_t);

  logic [11:0] frame_width_q, frame_height_q;
  logic [8:0]  sharpness_q;

  cacs_pkg::pix_t                 pix_in;
  logic                           job_v;
  cacs_pkg::job_t                 job_f, job_b;
  logic [CW-1:0]                  job_col_f, job_col_b;
  logic [RW-1:0]                  job_row_f, job_row_b;
  logic [JQW-1:0]                 jq_wdata, jq_rdata;
  logic                           jq_empty, jq_pop;
  logic [cacs_pkg::JQ_CNTW-1:0]   jq_cnt;

  logic                           oq_wr0, oq_wr1;
  cacs_pkg::res_t                 oq_wd0, oq_wd1, oq_head;
  logic [OQW-1:0]                 oq_rdata;
  logic [cacs_pkg::OQ_CNTW-1:0]   oq_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= cacs_pkg::FRAME_WIDTH_RST;
      frame_height_q <= cacs_pkg::FRAME_HEIGHT_RST;
      sharpness_q    <= cacs_pkg::SHARPNESS_RST;
    end else if (cfg_we_i) begin
      unique case (cacs_pkg::cfg_reg_e'(cfg_idx_i))
        cacs_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        cacs_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        cacs_pkg::REG_SHARPNESS:    sharpness_q    <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pix_in.red   = pix_red_i;
    pix_in.green = pix_green_i;
    pix_in.blue  = pix_blue_i;
    pix_in.alpha = pix_alpha_i;
  end

  cacs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .pix_i          (pix_in),
    .frame_start_i  (frame_start_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .jq_cnt_i       (jq_cnt),
    .job_v_o        (job_v),
    .job_o          (job_f),
    .job_col_o      (job_col_f),
    .job_row_o      (job_row_f)
  );

  assign jq_wdata = {job_f, job_col_f, job_row_f};

  cacs_fifo #(
    .DW    (JQW),
    .DEPTH (cacs_pkg::JQ_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr0_i   (job_v),
    .wd0_i   (jq_wdata),
    .wr1_i   (1'b0),
    .wd1_i   ({JQW{1'b0}}),
    .rd_i    (jq_pop),
    .rdata_o (jq_rdata),
    .empty_o (jq_empty),
    .cnt_o   (jq_cnt)
  );

  assign job_b     = cacs_pkg::job_t'(jq_rdata[JQW-1 -: JOBW]);
  assign job_col_b = jq_rdata[RW +: CW];
  assign job_row_b = jq_rdata[RW-1:0];

  cacs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sharpness_i (sharpness_q),
    .jq_empty_i  (jq_empty),
    .jq_pop_o    (jq_pop),
    .job_i       (job_b),
    .job_col_i   (job_col_b),
    .job_row_i   (job_row_b),
    .oq_cnt_i    (oq_cnt),
    .oq_wr0_o    (oq_wr0),
    .oq_wd0_o    (oq_wd0),
    .oq_wr1_o    (oq_wr1),
    .oq_wd1_o    (oq_wd1)
  );

  cacs_fifo #(
    .DW    (OQW),
    .DEPTH (cacs_pkg::OQ_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr0_i   (oq_wr0),
    .wd0_i   (oq_wd0),
    .wr1_i   (oq_wr1),
    .wd1_i   (oq_wd1),
    .rd_i    (pop),
    .rdata_o (oq_rdata),
    .empty_o (empty),
    .cnt_o   (oq_cnt)
  );

  assign oq_head     = cacs_pkg::res_t'(oq_rdata);
  assign out_red_o   = oq_head.pix.red;
  assign out_green_o = oq_head.pix.green;
  assign out_blue_o  = oq_head.pix.blue;
  assign out_alpha_o = oq_head.pix.alpha;
  assign out_col_o   = oq_head.col;
  assign out_row_o   = oq_head.row;
  assign run_last_o  = oq_head.last;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for the contrast adaptive cross sharpening core: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_W      = 2048;
  localparam int MAX_H      = 2048;
  localparam int SETTLE     = 24;
  localparam int RANDOM_PIX = 2000;
  localparam int unsigned LIMIT = 8_000_000;

  // Tracks line stores, window and position; predicts every emitted pixel.
  class sharpen_scoreboard;
    cacs_pkg::pix_t line_up1 [MAX_W];
    cacs_pkg::pix_t line_up2 [MAX_W];
    cacs_pkg::pix_t win [9];
    int unsigned    col_pos;
    int unsigned    row_pos;
    logic [11:0]    width_reg;
    logic [11:0]    height_reg;
    logic [8:0]     sharp_reg;
    cacs_pkg::res_t pending_pixels [$];
    int unsigned    mismatches;
    int unsigned    checked;

    function new();
      foreach (win[i]) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = cacs_pkg::FRAME_WIDTH_RST;
      height_reg = cacs_pkg::FRAME_HEIGHT_RST;
      sharp_reg  = cacs_pkg::SHARPNESS_RST;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(cacs_pkg::cfg_reg_e idx, logic [11:0] val);
      case (idx)
        cacs_pkg::REG_FRAME_WIDTH:  width_reg  = val;
        cacs_pkg::REG_FRAME_HEIGHT: height_reg = val;
        cacs_pkg::REG_SHARPNESS:    sharp_reg  = val[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [11:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned width_now();
      return clamp_dim(width_reg, MAX_W);
    endfunction

    function int unsigned outstanding();
      return pending_pixels.size();
    endfunction

    function int unsigned brightness(cacs_pkg::pix_t p);
      return 77 * p.red + 150 * p.green + 29 * p.blue;
    endfunction

    function logic [7:0] sharpen_chan(logic [7:0] cen, logic [7:0] lf, logic [7:0] rt,
                                      logic [7:0] up, logic [7:0] dn, longint gain);
      longint c0;
      longint nsum;
      longint num;
      c0   = cen;
      nsum = longint'(lf) + longint'(rt) + longint'(up) + longint'(dn);
      num  = c0 * 524288 + gain * (4 * c0 - nsum);
      if (num < 0) return 8'd0;
      num = num >>> 19;
      if (num > 255) return 8'hFF;
      return num[7:0];
    endfunction

    function void take_pixel(cacs_pkg::pix_t p, bit fs);
      int unsigned    w, h, col, row, mn, mx, lim, s;
      int unsigned    lum [5];
      longint         gain;
      cacs_pkg::pix_t up1, up2, c;
      cacs_pkg::res_t due [2];
      int             n;
      w   = clamp_dim(width_reg, MAX_W);
      h   = clamp_dim(height_reg, MAX_H);
      col = fs ? 0 : col_pos;
      row = fs ? 0 : row_pos;
      n   = 0;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;

      up1 = line_up1[col];
      up2 = line_up2[col];
      line_up2[col] = up1;
      line_up1[col] = p;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = p;

      // Interior pixel one row up and one column left is now complete.
      if (col >= 2 && row >= 2) begin
        lum[0] = brightness(win[4]);
        lum[1] = brightness(win[3]);
        lum[2] = brightness(win[5]);
        lum[3] = brightness(win[1]);
        lum[4] = brightness(win[7]);
        mn = lum[0];
        mx = lum[0];
        for (int i = 1; i < 5; i++) begin
          if (lum[i] < mn) mn = lum[i];
          if (lum[i] > mx) mx = lum[i];
        end
        lim  = (mx - mn) * 4 < 256 ? (mx - mn) * 4 : 256;
        s    = sharp_reg > 256 ? 256 : sharp_reg;
        gain = longint'(s) * longint'(lim);
        c    = win[4];
        c.red   = sharpen_chan(win[4].red, win[3].red, win[5].red, win[1].red,
                               win[7].red, gain);
        c.green = sharpen_chan(win[4].green, win[3].green, win[5].green, win[1].green,
                               win[7].green, gain);
        c.blue  = sharpen_chan(win[4].blue, win[3].blue, win[5].blue, win[1].blue,
                               win[7].blue, gain);
        due[n].pix  = c;
        due[n].col  = cacs_pkg::POS_W'(col - 1);
        due[n].row  = cacs_pkg::POS_W'(row - 1);
        due[n].last = 1'b0;
        n++;
      end

      if (col == 0 || row == 0 || col == w - 1 || row == h - 1) begin
        due[n].pix  = p;
        due[n].col  = cacs_pkg::POS_W'(col);
        due[n].row  = cacs_pkg::POS_W'(row);
        due[n].last = 1'b0;
        n++;
      end

      if (n > 0) due[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_pixels.push_back(due[i]);

      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      col_pos = col;
      row_pos = row;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 30) $display("mismatch: %s", what);
    endtask

    task check_pixel(cacs_pkg::res_t got);
      cacs_pkg::res_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected word at col %0d row %0d", got.col, got.row));
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (got.pix.red !== want.pix.red)
        report_mismatch($sformatf("red %0d, want %0d at col %0d row %0d",
                                  got.pix.red, want.pix.red, want.col, want.row));
      if (got.pix.green !== want.pix.green)
        report_mismatch($sformatf("green %0d, want %0d at col %0d row %0d",
                                  got.pix.green, want.pix.green, want.col, want.row));
      if (got.pix.blue !== want.pix.blue)
        report_mismatch($sformatf("blue %0d, want %0d at col %0d row %0d",
                                  got.pix.blue, want.pix.blue, want.col, want.row));
      if (got.pix.alpha !== want.pix.alpha)
        report_mismatch($sformatf("alpha %0d, want %0d at col %0d row %0d",
                                  got.pix.alpha, want.pix.alpha, want.col, want.row));
      if (got.col !== want.col)
        report_mismatch($sformatf("col %0d, want %0d", got.col, want.col));
      if (got.row !== want.row)
        report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b at col %0d row %0d",
                                  got.last, want.last, want.col, want.row));
    endtask
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          push          = 1'b0;
  logic                          full;
  logic [7:0]                    pix_red_i     = '0;
  logic [7:0]                    pix_green_i   = '0;
  logic [7:0]                    pix_blue_i    = '0;
  logic [7:0]                    pix_alpha_i   = '0;
  logic                          frame_start_i = 1'b0;
  logic                          empty;
  logic                          pop           = 1'b0;
  logic [7:0]                    out_red_o;
  logic [7:0]                    out_green_o;
  logic [7:0]                    out_blue_o;
  logic [7:0]                    out_alpha_o;
  logic [10:0]                   out_col_o;
  logic [10:0]                   out_row_o;
  logic                          run_last_o;
  logic                          cfg_we_i      = 1'b0;
  logic [cacs_pkg::CFG_AW-1:0]   cfg_idx_i     = '0;
  logic [cacs_pkg::CFG_DW-1:0]   cfg_data_i    = '0;

  sharpen_scoreboard sb = new();

  bit          tx_idle_on  = 1'b0;
  bit          rx_idle_on  = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned pixels_in    = 0;
  int unsigned settings     = 0;
  int unsigned random_sent  = 0;
  int unsigned cycle_count  = 0;

  contrast_adaptive_cross_sharpen_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .pix_red_i     (pix_red_i),
    .pix_green_i   (pix_green_i),
    .pix_blue_i    (pix_blue_i),
    .pix_alpha_i   (pix_alpha_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_alpha_o   (out_alpha_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .run_last_o    (run_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles, %0d words still due", cycle_count, sb.outstanding());
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [11:0] pick_height();
    if ($urandom_range(99) < 80) return 12'($urandom_range(0, 12));
    return 12'($urandom_range(13, 40));
  endfunction

  function automatic logic [11:0] pick_sharp();
    case ($urandom_range(5))
      0:       return 12'd0;
      1:       return 12'd256;
      2:       return 12'd511;
      3:       return 12'($urandom());
      default: return 12'($urandom_range(0, 256));
    endcase
  endfunction

  // Flat regions with small noise keep contrast low; the rest mixes full-range, saturated and wider-noise pixels.
  function automatic cacs_pkg::pix_t make_pixel(cacs_pkg::pix_t base);
    cacs_pkg::pix_t p;
    int unsigned    r;
    r = $urandom_range(99);
    if (r < 35) begin
      p = $urandom();
    end else if (r < 70) begin
      p.red   = base.red   ^ 8'($urandom_range(7));
      p.green = base.green ^ 8'($urandom_range(7));
      p.blue  = base.blue  ^ 8'($urandom_range(7));
    end else if (r < 85) begin
      p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end else begin
      p.red   = base.red   ^ 8'($urandom_range(63));
      p.green = base.green ^ 8'($urandom_range(63));
      p.blue  = base.blue  ^ 8'($urandom_range(63));
    end
    p.alpha = 8'($urandom());
    return p;
  endfunction

  task automatic send_pixel(cacs_pkg::pix_t p, bit fs);
    int unsigned gap;
    push          <= 1'b1;
    pix_red_i     <= p.red;
    pix_green_i   <= p.green;
    pix_blue_i    <= p.blue;
    pix_alpha_i   <= p.alpha;
    frame_start_i <= fs;
    do @(posedge clk_i); while (full);
    sb.take_pixel(p, fs);
    pixels_in++;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold input until every due word is out, then let the pipe go quiet.
  task automatic wait_for_results();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [11:0] w, logic [11:0] h, logic [11:0] s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cacs_pkg::REG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    sb.set_reg(cacs_pkg::REG_FRAME_WIDTH, w);
    cfg_idx_i  <= cacs_pkg::REG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    sb.set_reg(cacs_pkg::REG_FRAME_HEIGHT, h);
    cfg_idx_i  <= cacs_pkg::REG_SHARPNESS;
    cfg_data_i <= s;
    @(posedge clk_i);
    sb.set_reg(cacs_pkg::REG_SHARPNESS, s);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  task automatic random_phase(bit squeeze);
    logic [11:0]    w;
    int unsigned    n, split, r;
    cacs_pkg::pix_t base;
    bit             fs;
    r = $urandom_range(99);
    if (r < 70) w = 12'($urandom_range(1, 10));
    else if (r < 95) w = 12'($urandom_range(11, 64));
    else begin
      case ($urandom_range(2))
        0:       w = 12'd0;
        1:       w = 12'd2048;
        default: w = 12'hFFF;
      endcase
    end
    wait_for_results();
    program_regs(w, pick_height(), pick_sharp());
    tx_idle_on = $urandom_range(3) != 0;
    rx_idle_on = $urandom_range(3) != 0;
    n = $urandom_range(20, 250);
    if (squeeze) begin
      n = 200;
      rx_hold_left = 400;
    end
    split = ($urandom_range(2) == 0) ? $urandom_range(1, n - 1) : n;
    base  = $urandom();
    for (int k = 0; k < n; k++) begin
      // Change registers mid-frame; width never grows so the line stores stay valid.
      if (k == split) begin
        wait_for_results();
        program_regs(12'($urandom_range(sb.width_now())), pick_height(), pick_sharp());
      end
      fs = (k == 0) || ($urandom_range(63) == 0);
      if ($urandom_range(15) == 0) base = $urandom();
      send_pixel(make_pixel(base), fs);
    end
    random_sent += n;
  endtask

  // Result side: pop with random stalls, long hold when asked.
  initial begin
    cacs_pkg::res_t got;
    int unsigned    stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.pix.red   = out_red_o;
        got.pix.green = out_green_o;
        got.pix.blue  = out_blue_o;
        got.pix.alpha = out_alpha_o;
        got.col       = out_col_o;
        got.row       = out_row_o;
        got.last      = run_last_o;
        sb.check_pixel(got);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (rx_idle_on) stall = pick_gap();
      end
    end
  end

  initial begin
    cacs_pkg::pix_t p;
    bit             odd;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pixels under reset registers, then a 4x4 checkerboard at full strength.
    rx_idle_on = 1'b1;
    send_pixel(make_pixel('0), 1'b1);
    send_pixel(make_pixel('0), 1'b0);
    wait_for_results();
    program_regs(12'd4, 12'd4, 12'd256);
    for (int k = 0; k < 18; k++) begin
      odd     = ((k % 4) + ((k / 4) % 4)) % 2;
      p.red   = odd ? 8'hFF : 8'h00;
      p.green = odd ? 8'h00 : 8'hFF;
      p.blue  = odd ? 8'd200 : 8'd30;
      p.alpha = 8'(k * 37);
      // the last two run past the frame end and start the next one
      send_pixel(p, k == 0);
    end
    // Narrow the frame mid-row: position wraps into the next row; oversized values saturate.
    wait_for_results();
    program_regs(12'd2, 12'hFFF, 12'hFFF);
    for (int k = 0; k < 3; k++) send_pixel(make_pixel('0), 1'b0);
    // Zero sizes act as a single pixel.
    wait_for_results();
    program_regs(12'd0, 12'd0, 12'd0);
    send_pixel(make_pixel(8'hFF), 1'b1);
    send_pixel(make_pixel(8'hFF), 1'b0);

    // Oversized width register: a stretch of the first row, back to back.
    wait_for_results();
    program_regs(12'hFFF, 12'd3, 12'h3FF);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int k = 0; k < 40; k++) send_pixel(make_pixel(8'h80), k == 0);
    // Oversized height register on a one pixel wide frame.
    wait_for_results();
    program_regs(12'd1, 12'd4095, 12'd64);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int k = 0; k < 40; k++) send_pixel(make_pixel(8'h40), k == 0);

    random_phase(1'b1);
    while (random_sent < RANDOM_PIX) random_phase(1'b0);

    wait_for_results();
    $display("Sent %0d pixels through %0d register settings; %0d output words compared.",
             pixels_in, settings, sb.checked);
    $display("Included oversized registers, mid-frame register changes and a long stall.");
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cacs_pkg.sv
sv/cacs_fifo.sv
sv/cacs_front.sv
sv/cacs_back.sv
sv/contrast_adaptive_cross_sharpen_core.sv
verif/tb_top.sv
